// ===== hw/rtl/fir_filter_q16_unit_defines.svh =====
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared concurrent assertion wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_Q16_UNIT_DEFINES_SVH
`define FIR_FILTER_Q16_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FQ_ASSERT(label, clk, rst, prop, msg)
`define FQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/fir_q16_pkg.sv =====
// ----------------------------------------------------------------------------
// FIR filter package
// Constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fir_q16_pkg;

  localparam int MAX_TAPS = 32;
  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W = 6;
  localparam int SAMPLE_W = 16;
  localparam int ACC_W = 32;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(32);
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_MAX = TAP_CNT_W'(MAX_TAPS);
  localparam logic [ACC_W-1:0] ROUND_CONST = 32'h0000_8000;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef logic [TAP_IDX_W-1:0] tap_idx_t;
  typedef logic [TAP_CNT_W-1:0] tap_cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic shift_en;
    logic coef_we;
    logic clear;
    logic prod_en;
    logic out_load;
    tap_idx_t tap_idx;
    tap_idx_t hist_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hw/rtl/fir_filter_q16_unit.sv =====
// ----------------------------------------------------------------------------
// FIR filter, signed 16-bit, Q16 coefficients
// Direct-form FIR filter with a loadable coefficient store.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the transaction kind (0 filters a sample,
// 1 loads a coefficient); tdata carries the coefficient slot and the value.
// A load writes one coefficient slot and produces no output transaction.
// A sample shifts into the delay line and produces one output transaction
// holding the rounded sum of products, bits 31..16 of (sum + 0x8000).
// The sum is formed by one shared multiplier, one tap per cycle, over the K
// taps in use (at most 32): the MAC state issues the products, FLUSH lets
// the last one reach the accumulator and DONE loads the output register;
// with no taps in use, IDLE goes straight to DONE.
// The output register lets the next transaction be accepted while a result
// waits; if the receiver stalls, the following result waits in the controller
// and no further input is taken until the output register is free.
// The tap count is written on the cfg channel; the user must write it only
// while the block is idle, which the block does not enforce. Reset clears the
// delay line and the coefficient store and sets the tap count to 32.
// ----------------------------------------------------------------------------
module fir_filter_q16_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // coef_index [4:0], value [20:5], zero fill
  input  logic        s_axis_tuser,  // command [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // filtered_sample [15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  fir_q16_pkg::dp_cmd_t    cmd;
  fir_q16_pkg::dp_status_t status;
  logic signed [15:0]      out_data;

  fir_q16_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .command   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  fir_q16_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .coef_index (s_axis_tdata[4:0]),
    .value      ($signed(s_axis_tdata[20:5])),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data)
  );

  assign m_axis_tdata = out_data;

endmodule

// ===== hw/rtl/fir_q16_dp.sv =====
// ----------------------------------------------------------------------------
// FIR filter datapath
// Delay line, coefficient store, multiplier, accumulator and output register.
// ----------------------------------------------------------------------------
module fir_q16_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fir_q16_pkg::dp_cmd_t                   cmd,
  output fir_q16_pkg::dp_status_t                status,
  input  fir_q16_pkg::tap_idx_t                  coef_index,
  input  logic signed [fir_q16_pkg::SAMPLE_W-1:0] value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fir_q16_pkg::SAMPLE_W-1:0] out_data
);

  logic signed [fir_q16_pkg::SAMPLE_W-1:0] hist [fir_q16_pkg::MAX_TAPS];
  logic signed [fir_q16_pkg::SAMPLE_W-1:0] coef [fir_q16_pkg::MAX_TAPS];
  logic signed [fir_q16_pkg::ACC_W-1:0]    prod;
  logic                                    prod_valid;
  logic [fir_q16_pkg::ACC_W-1:0]           acc;
  logic [fir_q16_pkg::ACC_W-1:0]           rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fir_q16_pkg::MAX_TAPS; i++) begin
        hist[i] <= '0;
        coef[i] <= '0;
      end
    end else begin
      if (cmd.shift_en) begin
        hist[0] <= value;
        for (int i = 1; i < fir_q16_pkg::MAX_TAPS; i++) begin
          hist[i] <= hist[i-1];
        end
      end
      if (cmd.coef_we) begin
        coef[coef_index] <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= fir_q16_pkg::ACC_W'(coef[cmd.tap_idx]) * fir_q16_pkg::ACC_W'(hist[cmd.hist_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc <= '0;
    end else begin
      prod_valid <= cmd.prod_en;
      if (cmd.clear) begin
        acc <= '0;
      end else if (prod_valid) begin
        acc <= acc + prod;
      end
    end
  end

  assign rounded = acc + fir_q16_pkg::ROUND_CONST;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= rounded[fir_q16_pkg::ACC_W-1 -: fir_q16_pkg::SAMPLE_W];
    end
  end

  assign status.out_busy = out_valid & ~out_ready;

endmodule

// ===== hw/rtl/fir_q16_ctrl.sv =====
// ----------------------------------------------------------------------------
// FIR filter controller
// Sequences one multiply-accumulate per tap and holds the tap count register.
// ----------------------------------------------------------------------------
`include "fir_filter_q16_unit_defines.svh"

module fir_q16_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  fir_q16_pkg::tap_cnt_t      cfg_data,
  output fir_q16_pkg::dp_cmd_t       cmd,
  input  fir_q16_pkg::dp_status_t    status
);

  fir_q16_pkg::state_t   state;
  fir_q16_pkg::state_t   state_next;
  fir_q16_pkg::tap_cnt_t tap_count;
  fir_q16_pkg::tap_cnt_t taps;
  fir_q16_pkg::tap_cnt_t last_tap;
  fir_q16_pkg::tap_idx_t tap;
  fir_q16_pkg::tap_idx_t tap_next;
  logic                  in_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fir_q16_pkg::TAP_COUNT_RESET;
    end else if (cfg_valid) begin
      tap_count <= cfg_data;
    end
  end

  assign taps = (tap_count > fir_q16_pkg::TAP_COUNT_MAX) ? fir_q16_pkg::TAP_COUNT_MAX
                                                       : tap_count;
  assign last_tap = taps - fir_q16_pkg::TAP_CNT_W'(1);
  assign in_accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fir_q16_pkg::ST_IDLE;
      tap <= '0;
    end else begin
      state <= state_next;
      tap <= tap_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next = tap;
    in_ready = 1'b0;
    cmd = '0;
    cmd.tap_idx = tap;
    cmd.hist_idx = last_tap[fir_q16_pkg::TAP_IDX_W-1:0] - tap;
    unique case (state)
      fir_q16_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == fir_q16_pkg::CMD_LOAD) begin
            cmd.coef_we = 1'b1;
          end else begin
            cmd.shift_en = 1'b1;
            cmd.clear = 1'b1;
            tap_next = '0;
            state_next = (taps == '0) ? fir_q16_pkg::ST_DONE : fir_q16_pkg::ST_MAC;
          end
        end
      end
      fir_q16_pkg::ST_MAC: begin
        cmd.prod_en = 1'b1;
        tap_next = tap + fir_q16_pkg::TAP_IDX_W'(1);
        if ({1'b0, tap} == last_tap) begin
          state_next = fir_q16_pkg::ST_FLUSH;
        end
      end
      fir_q16_pkg::ST_FLUSH: begin
        state_next = fir_q16_pkg::ST_DONE;
      end
      fir_q16_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = fir_q16_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fir_q16_pkg::ST_IDLE;
      end
    endcase
  end

  `FQ_ASSERT(a_mac_in_range, clk, rst,
             (state == fir_q16_pkg::ST_MAC) |-> ({1'b0, tap} < taps),
             "Tap counter ran past the tap count.")
  `FQ_ASSERT(a_sample_starts, clk, rst,
             (in_accept && command == fir_q16_pkg::CMD_FILTER && taps != '0)
               |=> (state == fir_q16_pkg::ST_MAC),
             "Accepted sample did not start the accumulation.")
  `FQ_ASSERT(a_flush_after_mac, clk, rst,
             (state == fir_q16_pkg::ST_FLUSH) |-> ($past(state) == fir_q16_pkg::ST_MAC),
             "Flush entered without an accumulation.")
  `FQ_ASSERT(a_load_stays_idle, clk, rst,
             (in_accept && command == fir_q16_pkg::CMD_LOAD)
               |=> (state == fir_q16_pkg::ST_IDLE),
             "Coefficient load left the idle state.")

endmodule

// ===== tb/tb_fir_filter_q16_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the streaming Q16 FIR filter
// A short table of directed transactions is followed by random phases, each
// with its own tap count written while the block is idle. Every sample result
// is compared with a behavioural filter in the testbench, or for typed table
// rows with the row's value, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fir_filter_q16_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  slot;
    logic [15:0] val;
    logic        typed;
    logic [15:0] want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  logic signed [15:0] delay_line [fir_q16_pkg::MAX_TAPS];
  logic signed [15:0] coef_bank [fir_q16_pkg::MAX_TAPS];
  logic [5:0]         taps_set;
  logic [15:0]        pending_outputs [$];

  bit quiet = 1'b0;
  int rx_stall = 0;
  int rx_draw;
  int idle_cycles = 0;
  int err_count = 0;
  int samples_filtered = 0;
  int coefs_loaded = 0;
  int results_checked = 0;
  int tap_writes = 0;

  stim_row_t directed_rows [0:21] = '{
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h7FFF, 1'b1, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd31, 16'h8000, 1'b1, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd31, 16'h7FFF, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd0,  16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h7FFF, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h0001, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd31, 16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd30, 16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd29, 16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd28, 16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd0,  16'h0000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h8000, 1'b1, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd15, 16'h5555, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_LOAD,   5'd10, 16'hAAAA, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h5555, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'hAAAA, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'hFFFF, 1'b0, 16'h0000},
    '{fir_q16_pkg::CMD_FILTER, 5'd0,  16'h0000, 1'b0, 16'h0000}
  };

  logic [5:0] phase_taps [0:11] = '{6'd1, 6'd0, 6'd63, 6'd3, 6'd32, 6'd8, 6'd33,
                                    6'd16, 6'd2, 6'd5, 6'd12, 6'd31};

  fir_filter_q16_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic fir_step(input logic cmd, input logic [4:0] slot,
                          input logic signed [15:0] val,
                          output bit produced, output logic [15:0] y);
    int k;
    logic [31:0] acc;
    produced = 1'b0;
    y = '0;
    if (cmd == fir_q16_pkg::CMD_LOAD) begin
      if (int'(slot) < fir_q16_pkg::MAX_TAPS) coef_bank[slot] = val;
      coefs_loaded++;
    end else begin
      for (int i = fir_q16_pkg::MAX_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = val;
      k = (int'(taps_set) > fir_q16_pkg::MAX_TAPS) ? fir_q16_pkg::MAX_TAPS : int'(taps_set);
      acc = '0;
      for (int m = 0; m < k; m++) begin
        acc = acc + 32'(int'(coef_bank[m]) * int'(delay_line[k-1-m]));
      end
      acc = acc + fir_q16_pkg::ROUND_CONST;
      y = acc[31:16];
      produced = 1'b1;
      samples_filtered++;
    end
  endtask

  task automatic send_item(input logic cmd, input logic [4:0] slot, input logic [15:0] val,
                           input logic typed, input logic [15:0] want);
    int gap;
    bit produced;
    logic [15:0] y;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'b000, val, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    fir_step(cmd, slot, val, produced, y);
    if (produced) pending_outputs.push_back(typed ? want : y);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(input logic [5:0] k);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    taps_set = k;
    tap_writes++;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = 16'h7FFF;
      1: pick_value = 16'h8000;
      2: pick_value = 16'h0000;
      default: pick_value = 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("Unexpected output transaction: filtered_sample %0d",
                   $signed(m_axis_tdata));
      end else begin
        if (m_axis_tdata !== pending_outputs[0]) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("filtered_sample mismatch: expected %0d (%h), actual %0d (%h)",
                     $signed(pending_outputs[0]), pending_outputs[0],
                     $signed(m_axis_tdata), m_axis_tdata);
        end
        void'(pending_outputs.pop_front());
        results_checked++;
      end
      rx_draw = quiet ? 0 : $urandom_range(0, 4);
      rx_stall <= rx_draw;
      m_axis_tready <= (rx_draw == 0);
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= (rx_stall == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction", idle_cycles);
      $display("tb_fir_filter_q16_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic cmd;
    taps_set = fir_q16_pkg::TAP_COUNT_RESET;
    for (int i = 0; i < fir_q16_pkg::MAX_TAPS; i++) begin
      delay_line[i] = '0;
      coef_bank[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_item(directed_rows[r].cmd, directed_rows[r].slot, directed_rows[r].val,
                directed_rows[r].typed, directed_rows[r].want);

    foreach (phase_taps[p]) begin
      write_taps(phase_taps[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
        cmd = ($urandom_range(0, 3) == 0) ? fir_q16_pkg::CMD_LOAD : fir_q16_pkg::CMD_FILTER;
        send_item(cmd, 5'($urandom_range(0, 31)), pick_value(), 1'b0, 16'h0000);
      end
    end

    wait_idle();
    $display("Covered %0d samples and %0d coefficient loads over %0d tap count settings.",
             samples_filtered, coefs_loaded, tap_writes + 1);
    $display("Checked %0d output transactions, %0d failures.", results_checked, err_count);
    if (err_count == 0) begin
      $display("tb_fir_filter_q16_unit: done, clean");
    end else begin
      $display("tb_fir_filter_q16_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fir_q16_pkg.sv
hw/rtl/fir_q16_dp.sv
hw/rtl/fir_q16_ctrl.sv
hw/rtl/fir_filter_q16_unit.sv
tb/tb_fir_filter_q16_unit.sv
